// File: rtl/core/pdmm_pkg.sv
`default_nettype none

package pdmm_pkg;

    // field widths of the request and response items
    localparam int unsigned MONTH_W = 4;
    localparam int unsigned DAY_W   = 5;
    localparam int unsigned TEMP_W  = 16;

    // wide enough for month * days + day at the largest table size
    localparam int unsigned IDX_FULL_W = 10;

    // request queue between front and back
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QCOUNT_W    = 2;

    // table word: seen flag, minimum, maximum
    localparam int unsigned WORD_W = 1 + 2 * TEMP_W;

    typedef enum logic
    {
        REQ_RECORD = 1'b0,
        REQ_READ   = 1'b1
    } pdmm_req_t;

    // one queued request, already classified by the front
    typedef struct packed
    {
        pdmm_req_t                 kind;
        logic                      in_range;
        logic [MONTH_W-1:0]        month;
        logic [DAY_W-1:0]          day;
        logic signed [TEMP_W-1:0]  temperature;
    } pdmm_entry_t;

    // queue head as seen by the back
    typedef struct packed
    {
        logic        valid;
        pdmm_entry_t entry;
    } pdmm_queue_t;

    // back to front control
    typedef struct packed
    {
        logic pop;
        logic clearing;
    } pdmm_ctrl_t;

    // layout of one table word
    typedef struct packed
    {
        logic                     seen;
        logic signed [TEMP_W-1:0] low;
        logic signed [TEMP_W-1:0] high;
    } pdmm_word_t;

endpackage

`default_nettype wire

// File: rtl/core/per_day_min_max_table.sv
// a read request is held in the request queue, the table read and the response register
// one request at a time in the back, set by the read-modify-write of the table memory
// a two-entry request queue lets the front keep accepting while the response stalls
// reset: after rst_n rises the table is swept clear, all NUM_MONTHS*NUM_DAYS words
// (416 at the defaults), with req_stall high; records with day zero or out of range drop
`default_nettype none

module per_day_min_max_table #(
    parameter int unsigned NUM_MONTHS = 13,
    parameter int unsigned NUM_DAYS   = 32
) (
    input  wire logic                                    clk,
    input  wire logic                                    rst_n,
    input  wire logic                                    req_valid,
    output logic                                         req_stall,
    input  wire logic                                    req_type,
    input  wire logic [pdmm_pkg::MONTH_W-1:0]            month,
    input  wire logic [pdmm_pkg::DAY_W-1:0]              day,
    input  wire logic signed [pdmm_pkg::TEMP_W-1:0]      temperature,
    output logic                                         rsp_valid,
    input  wire logic                                    rsp_stall,
    output logic                                         entry_valid,
    output logic signed [pdmm_pkg::TEMP_W-1:0]           min_temp,
    output logic signed [pdmm_pkg::TEMP_W-1:0]           max_temp
);

    import pdmm_pkg::*;

    pdmm_queue_t head;
    pdmm_ctrl_t  ctrl;

    // accept and classify, queue
    pdmm_front #(
        .NUM_MONTHS (NUM_MONTHS),
        .NUM_DAYS   (NUM_DAYS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .req_type    (req_type),
        .month       (month),
        .day         (day),
        .temperature (temperature),
        .ctrl        (ctrl),
        .head        (head)
    );

    // table update and lookup
    pdmm_back #(
        .NUM_MONTHS (NUM_MONTHS),
        .NUM_DAYS   (NUM_DAYS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .ctrl        (ctrl),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .entry_valid (entry_valid),
        .min_temp    (min_temp),
        .max_temp    (max_temp)
    );

    // no request taken while the table is being cleared
    assert property (@(posedge clk) disable iff (!rst_n) ctrl.clearing |-> req_stall)
        else $error("request accepted during table clear");

    // the back only pops a queue that holds something
    assert property (@(posedge clk) disable iff (!rst_n) ctrl.pop |-> head.valid)
        else $error("pop from empty request queue");

    // the clear sweep runs once, right after reset
    assert property (@(posedge clk) disable iff (!rst_n) !$rose(ctrl.clearing))
        else $error("table clear restarted");

    // a response never starts while the table is still being cleared
    assert property (@(posedge clk) disable iff (!rst_n) ctrl.clearing |-> !rsp_valid)
        else $error("response during table clear");

endmodule

`default_nettype wire

// File: rtl/core/pdmm_ram.sv
`default_nettype none

module pdmm_ram #(
    parameter int unsigned WIDTH = 33,
    parameter int unsigned DEPTH = 416
) (
    input  wire logic                                        clk,
    input  wire logic                                        we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                            wdata,
    input  wire logic                                        rd_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                            rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // single write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read, held while no read is issued
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/pdmm_front.sv
`default_nettype none

module pdmm_front #(
    parameter int unsigned NUM_MONTHS = 13,
    parameter int unsigned NUM_DAYS   = 32
) (
    input  wire logic                                    clk,
    input  wire logic                                    rst_n,
    input  wire logic                                    req_valid,
    output logic                                         req_stall,
    input  wire logic                                    req_type,
    input  wire logic [pdmm_pkg::MONTH_W-1:0]            month,
    input  wire logic [pdmm_pkg::DAY_W-1:0]              day,
    input  wire logic signed [pdmm_pkg::TEMP_W-1:0]      temperature,
    input  wire pdmm_pkg::pdmm_ctrl_t                    ctrl,
    output pdmm_pkg::pdmm_queue_t                        head
);

    import pdmm_pkg::*;

    pdmm_entry_t           entry_reg [QUEUE_DEPTH];
    logic                  wr_ptr_reg;
    logic                  wr_ptr_next;
    logic                  rd_ptr_reg;
    logic                  rd_ptr_next;
    logic [QCOUNT_W-1:0]   count_reg;
    logic [QCOUNT_W-1:0]   count_next;
    logic                  accept;
    logic                  in_range;
    logic                  keep;
    logic                  push;
    pdmm_entry_t           new_entry;

    // classify the incoming request
    assign in_range = (5'(month) < 5'(NUM_MONTHS)) && (6'(day) < 6'(NUM_DAYS));
    assign keep     = (pdmm_req_t'(req_type) == REQ_READ) || ((day != '0) && in_range);

    assign new_entry.kind        = pdmm_req_t'(req_type);
    assign new_entry.in_range    = in_range;
    assign new_entry.month       = month;
    assign new_entry.day         = day;
    assign new_entry.temperature = temperature;

    // handshake: hold off during the table clear or with a full queue
    assign req_stall = ctrl.clearing || (count_reg == QCOUNT_W'(QUEUE_DEPTH));
    assign accept    = req_valid && !req_stall;
    assign push      = accept && keep;

    // queue pointers and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = ~wr_ptr_reg;
        end
        if (ctrl.pop)
        begin
            rd_ptr_next = ~rd_ptr_reg;
        end
        priority if (push && !ctrl.pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && ctrl.pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= new_entry;
        end
    end

    assign head.valid = (count_reg != '0);
    assign head.entry = entry_reg[rd_ptr_reg];

endmodule

`default_nettype wire

// File: rtl/core/pdmm_back.sv
`default_nettype none

module pdmm_back #(
    parameter int unsigned NUM_MONTHS = 13,
    parameter int unsigned NUM_DAYS   = 32
) (
    input  wire logic                                    clk,
    input  wire logic                                    rst_n,
    input  wire pdmm_pkg::pdmm_queue_t                   head,
    output pdmm_pkg::pdmm_ctrl_t                         ctrl,
    output logic                                         rsp_valid,
    input  wire logic                                    rsp_stall,
    output logic                                         entry_valid,
    output logic signed [pdmm_pkg::TEMP_W-1:0]           min_temp,
    output logic signed [pdmm_pkg::TEMP_W-1:0]           max_temp
);

    import pdmm_pkg::*;

    localparam int unsigned DEPTH = NUM_MONTHS * NUM_DAYS;
    localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

    typedef enum logic [2:0]
    {
        ST_CLEAR = 3'b001,
        ST_IDLE  = 3'b010,
        ST_EXEC  = 3'b100
    } state_t;

    state_t                    state_reg;
    state_t                    state_next;
    logic [IDX_W-1:0]          clr_cnt_reg;
    logic [IDX_W-1:0]          clr_cnt_next;
    pdmm_entry_t               cur_reg;
    pdmm_entry_t               cur_next;
    logic                      rsp_valid_reg;
    logic                      rsp_valid_next;
    logic                      entry_valid_reg;
    logic                      entry_valid_next;
    logic signed [TEMP_W-1:0]  min_temp_reg;
    logic signed [TEMP_W-1:0]  min_temp_next;
    logic signed [TEMP_W-1:0]  max_temp_reg;
    logic signed [TEMP_W-1:0]  max_temp_next;
    logic [IDX_FULL_W-1:0]     head_idx_full;
    logic [IDX_FULL_W-1:0]     cur_idx_full;
    logic                      ram_we;
    logic [IDX_W-1:0]          ram_waddr;
    logic [WORD_W-1:0]         ram_wdata;
    logic                      ram_rd_en;
    logic [WORD_W-1:0]         ram_rdata;
    pdmm_word_t                old_word;
    pdmm_word_t                upd_word;

    // entry index is month * days + day
    assign head_idx_full = IDX_FULL_W'(head.entry.month) * IDX_FULL_W'(NUM_DAYS)
                         + IDX_FULL_W'(head.entry.day);
    assign cur_idx_full  = IDX_FULL_W'(cur_reg.month) * IDX_FULL_W'(NUM_DAYS)
                         + IDX_FULL_W'(cur_reg.day);

    pdmm_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .rd_en (ram_rd_en),
        .raddr (head_idx_full[IDX_W-1:0]),
        .rdata (ram_rdata)
    );

    // merge a sample into the stored entry
    assign old_word = pdmm_word_t'(ram_rdata);
    always_comb
    begin
        upd_word.seen = 1'b1;
        if (!old_word.seen)
        begin
            upd_word.low  = cur_reg.temperature;
            upd_word.high = cur_reg.temperature;
        end
        else
        begin
            upd_word.low  = (cur_reg.temperature < old_word.low) ?
                            cur_reg.temperature : old_word.low;
            upd_word.high = (cur_reg.temperature > old_word.high) ?
                            cur_reg.temperature : old_word.high;
        end
    end

    // sequencer: clear sweep, fetch, then update or respond
    always_comb
    begin
        state_next       = state_reg;
        clr_cnt_next     = clr_cnt_reg;
        cur_next         = cur_reg;
        ram_we           = 1'b0;
        ram_waddr        = cur_idx_full[IDX_W-1:0];
        ram_wdata        = WORD_W'(upd_word);
        ram_rd_en        = 1'b0;
        ctrl.pop         = 1'b0;
        ctrl.clearing    = (state_reg == ST_CLEAR);
        rsp_valid_next   = rsp_valid_reg && rsp_stall;
        entry_valid_next = entry_valid_reg;
        min_temp_next    = min_temp_reg;
        max_temp_next    = max_temp_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we       = 1'b1;
                ram_waddr    = clr_cnt_reg;
                ram_wdata    = '0;
                clr_cnt_next = IDX_W'(clr_cnt_reg + 1'b1);
                if (clr_cnt_reg == LAST_IDX)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (head.valid)
                begin
                    ctrl.pop   = 1'b1;
                    ram_rd_en  = 1'b1;
                    cur_next   = head.entry;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (cur_reg.kind == REQ_RECORD)
                begin
                    ram_we     = 1'b1;
                    state_next = ST_IDLE;
                end
                else if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next   = 1'b1;
                    entry_valid_next = cur_reg.in_range && old_word.seen;
                    min_temp_next    = entry_valid_next ? old_word.low : '0;
                    max_temp_next    = entry_valid_next ? old_word.high : '0;
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        cur_reg         <= cur_next;
        entry_valid_reg <= entry_valid_next;
        min_temp_reg    <= min_temp_next;
        max_temp_reg    <= max_temp_next;
    end

    assign rsp_valid   = rsp_valid_reg;
    assign entry_valid = entry_valid_reg;
    assign min_temp    = min_temp_reg;
    assign max_temp    = max_temp_reg;

endmodule

`default_nettype wire
